FILE: design/mfw_pkg.sv
// Shared constants, types and helpers of the median filter window block.
// No dependencies; every other design file imports this package.
package mfw_pkg;

  localparam int unsigned MaxWidth   = 1024;
  localparam int unsigned MaxRadius  = 3;
  localparam int unsigned StoreRows  = 2 * MaxRadius + 1;
  localparam int unsigned WinSize    = StoreRows * StoreRows;
  localparam int unsigned ColW       = $clog2(MaxWidth);
  localparam int unsigned RowPtrW    = $clog2(StoreRows);
  localparam int unsigned RankW      = $clog2(WinSize);
  localparam int unsigned PixW       = 8;
  localparam int unsigned RadW       = 2;
  localparam int unsigned WidthW     = 11;
  localparam int unsigned HeightW    = 16;
  localparam int unsigned CountW     = 26;
  localparam int unsigned LagW       = 12;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;

  typedef logic [PixW-1:0] pix_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RADIUS = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  // Read request and side data of one item, from the counters to the window
  typedef struct packed {
    logic               due;
    logic               fend;
    logic               border;
    logic [RadW-1:0]    rad;
    logic [RowPtrW-1:0] row_a;
    logic [ColW-1:0]    col_a;
    logic [RowPtrW-1:0] row_b;
    logic [ColW-1:0]    col_b;
  } issue_t;

  // Line store write of one item
  typedef struct packed {
    logic               en;
    logic [RowPtrW-1:0] row;
    logic [ColW-1:0]    col;
    pix_t               data;
  } wr_t;

  // Reduce a small sum of row pointers back into 0 .. StoreRows-1
  function automatic logic [RowPtrW-1:0] row_wrap(input logic [4:0] v);
    logic [4:0] t;
    t = v;
    if (t >= 5'(StoreRows)) t = t - 5'(StoreRows);
    if (t >= 5'(StoreRows)) t = t - 5'(StoreRows);
    return t[RowPtrW-1:0];
  endfunction

endpackage

FILE: design/mfw_if.sv
// Handshake channels of the median filter window: pixel in, pixel out, config.
// Depends on mfw_pkg for field widths.
interface mfw_pix_in_if
  import mfw_pkg::*;
;
  logic valid;
  logic ready;
  logic mode;
  pix_t pixel_in;

  modport source (output valid, output mode, output pixel_in, input ready);
  modport sink   (input valid, input mode, input pixel_in, output ready);
endinterface

interface mfw_pix_out_if
  import mfw_pkg::*;
;
  logic valid;
  logic ready;
  pix_t pixel_out;
  logic frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

interface mfw_cfg_if
  import mfw_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/mfw_line_ram.sv
// One row of the line store: one write port, two registered read ports.
// Depends on mfw_pkg; a write to the address being read is forwarded.
module mfw_line_ram
  import mfw_pkg::*;
(
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [ColW-1:0] waddr_i,
  input  pix_t            wdata_i,
  input  logic            re_i,
  input  logic [ColW-1:0] raddr_a_i,
  input  logic [ColW-1:0] raddr_b_i,
  output pix_t            rdata_a_o,
  output pix_t            rdata_b_o
);

  pix_t mem_q [MaxWidth];
  pix_t rdata_a_q;
  pix_t rdata_b_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read ports, hold the data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= (we_i && (waddr_i == raddr_a_i)) ? wdata_i : mem_q[raddr_a_i];
      rdata_b_q <= (we_i && (waddr_i == raddr_b_i)) ? wdata_i : mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: design/mfw_ctrl.sv
// Config registers and raster counters: line store writes, output scheduling.
// Depends on mfw_pkg and the channel interfaces in mfw_if.
module mfw_ctrl
  import mfw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  mfw_cfg_if.sink    cfg_i,
  mfw_pix_in_if.sink pix_in_i,
  input  logic       in_ready_i,
  output issue_t     iss_o,
  output wr_t        wr_o
);

  function automatic logic [WidthW-1:0] eff_width(input logic [WidthW-1:0] v);
    logic [WidthW-1:0] res;
    res = v;
    if (v == '0) res = WidthW'(1);
    else if (32'(v) > MaxWidth) res = WidthW'(MaxWidth);
    return res;
  endfunction

  function automatic logic [LagW-1:0] calc_lag(input logic [RadW-1:0] r,
                                                input logic [WidthW-1:0] w);
    return LagW'(w) * LagW'(r) + LagW'(r);
  endfunction

  function automatic logic [CountW-1:0] calc_total(input logic [WidthW-1:0] w,
                                                    input logic [HeightW-1:0] h);
    return CountW'(w) * CountW'(h);
  endfunction

  function automatic logic [RowPtrW-1:0] row_inc(input logic [RowPtrW-1:0] p);
    return (p == RowPtrW'(StoreRows - 1)) ? '0 : p + RowPtrW'(1);
  endfunction

  logic [RadW-1:0]    rad_q, rad_d;
  logic [WidthW-1:0]  wid_q, wid_d;
  logic [HeightW-1:0] hgt_q, hgt_d;
  logic [CountW-1:0]  total_q, total_d;
  logic [LagW-1:0]    lag_q, lag_d;

  logic [ColW-1:0]    wcol_q, wcol_d;
  logic [RowPtrW-1:0] wrow_q, wrow_d;
  logic [CountW-1:0]  avail_q, avail_d;
  logic [CountW-1:0]  emit_q, emit_d;
  logic [ColW-1:0]    ex_q, ex_d;
  logic [HeightW-1:0] ey_q, ey_d;
  logic [RowPtrW-1:0] ey7_q, ey7_d;
  logic [ColW-1:0]    fc_q, fc_d;
  logic [RowPtrW-1:0] fr7_q, fr7_d;

  logic              cfg_acc;
  logic              accept;
  logic              wr_en;
  logic [CountW-1:0] avail_n;
  logic              restart;
  logic              due;
  logic              last;
  logic              border;

  assign cfg_i.ready    = 1'b1;
  assign cfg_acc        = cfg_i.valid;
  assign pix_in_i.ready = in_ready_i;
  assign accept         = pix_in_i.valid && in_ready_i;

  // Config writes; frame size and lag follow the new value at once
  always_comb begin
    rad_d   = rad_q;
    wid_d   = wid_q;
    hgt_d   = hgt_q;
    total_d = total_q;
    lag_d   = lag_q;
    if (cfg_acc) begin
      case (cfg_i.index)
        CFG_RADIUS: begin
          rad_d = cfg_i.data[RadW-1:0];
          lag_d = calc_lag(cfg_i.data[RadW-1:0], wid_q);
        end
        CFG_WIDTH: begin
          wid_d   = eff_width(cfg_i.data[WidthW-1:0]);
          lag_d   = calc_lag(rad_q, eff_width(cfg_i.data[WidthW-1:0]));
          total_d = calc_total(eff_width(cfg_i.data[WidthW-1:0]), hgt_q);
        end
        CFG_HEIGHT: begin
          hgt_d   = (cfg_i.data == '0) ? HeightW'(1) : cfg_i.data;
          total_d = calc_total(wid_q, (cfg_i.data == '0) ? HeightW'(1) : cfg_i.data);
        end
        default: begin
        end
      endcase
    end
  end

  // Decide write and emission of the item on the port
  always_comb begin
    wr_en   = !pix_in_i.mode && (avail_q < total_q);
    avail_n = avail_q + CountW'(wr_en);
    restart = emit_q >= total_q;
    due     = !restart &&
              (((CountW + 1)'(emit_q) + (CountW + 1)'(lag_q) < (CountW + 1)'(avail_n)) ||
               (avail_n >= total_q));
    last    = due && ((emit_q + CountW'(1)) >= total_q);
    border  = (ey_q < HeightW'(rad_q)) || (ex_q < ColW'(rad_q)) ||
              (((HeightW + 1)'(ey_q) + (HeightW + 1)'(rad_q)) >= (HeightW + 1)'(hgt_q)) ||
              ((WidthW'(ex_q) + WidthW'(rad_q)) >= wid_q);
  end

  // Advance the write and emission counters
  always_comb begin
    wcol_d  = wcol_q;
    wrow_d  = wrow_q;
    avail_d = avail_q;
    emit_d  = emit_q;
    ex_d    = ex_q;
    ey_d    = ey_q;
    ey7_d   = ey7_q;
    fc_d    = fc_q;
    fr7_d   = fr7_q;
    if (accept) begin
      avail_d = avail_n;
      if (wr_en) begin
        if ((WidthW'(wcol_q) + WidthW'(1)) >= wid_q) begin
          wcol_d = '0;
          wrow_d = row_inc(wrow_q);
        end else begin
          wcol_d = wcol_q + ColW'(1);
        end
      end
      if (due) begin
        emit_d = emit_q + CountW'(1);
        if ((WidthW'(ex_q) + WidthW'(1)) >= wid_q) begin
          ex_d  = '0;
          ey_d  = ey_q + HeightW'(1);
          ey7_d = row_inc(ey7_q);
        end else begin
          ex_d = ex_q + ColW'(1);
        end
        if ((WidthW'(fc_q) + WidthW'(1)) >= wid_q) begin
          fc_d  = '0;
          fr7_d = row_inc(fr7_q);
        end else begin
          fc_d = fc_q + ColW'(1);
        end
      end
      // Start a new frame
      if (restart || last) begin
        wcol_d  = '0;
        wrow_d  = '0;
        avail_d = '0;
        emit_d  = '0;
        ex_d    = '0;
        ey_d    = '0;
        ey7_d   = '0;
        fc_d    = (WidthW'(rad_q) < wid_q) ? ColW'(rad_q) : '0;
        fr7_d   = '0;
      end
    end
    // Realign the first fetch column to a new window size before any output
    if (cfg_acc && (emit_d == '0)) begin
      fc_d = (WidthW'(rad_d) < wid_d) ? ColW'(rad_d) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q   <= RadW'(1);
      wid_q   <= WidthW'(640);
      hgt_q   <= HeightW'(480);
      total_q <= CountW'(640 * 480);
      lag_q   <= LagW'(641);
      wcol_q  <= '0;
      wrow_q  <= '0;
      avail_q <= '0;
      emit_q  <= '0;
      ex_q    <= '0;
      ey_q    <= '0;
      ey7_q   <= '0;
      fc_q    <= ColW'(1);
      fr7_q   <= '0;
    end else begin
      rad_q   <= rad_d;
      wid_q   <= wid_d;
      hgt_q   <= hgt_d;
      total_q <= total_d;
      lag_q   <= lag_d;
      wcol_q  <= wcol_d;
      wrow_q  <= wrow_d;
      avail_q <= avail_d;
      emit_q  <= emit_d;
      ex_q    <= ex_d;
      ey_q    <= ey_d;
      ey7_q   <= ey7_d;
      fc_q    <= fc_d;
      fr7_q   <= fr7_d;
    end
  end

  always_comb begin
    iss_o.due    = accept && due;
    iss_o.fend   = last;
    iss_o.border = border;
    iss_o.rad    = rad_q;
    iss_o.row_a  = fr7_q;
    iss_o.col_a  = fc_q;
    iss_o.row_b  = ey7_q;
    iss_o.col_b  = ex_q;
    wr_o.en      = accept && wr_en;
    wr_o.row     = wrow_q;
    wr_o.col     = wcol_q;
    wr_o.data    = pix_in_i.pixel_in;
  end

endmodule

FILE: design/mfw_median.sv
// Sliding window registers and bitwise median pipeline, one stage per bit.
// Depends on mfw_pkg and mfw_if; takes read data from the line store rows.
module mfw_median
  import mfw_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  issue_t       iss_i,
  input  pix_t         rd_a_i [StoreRows],
  input  pix_t         rd_b_i [StoreRows],
  output logic         in_ready_o,
  mfw_pix_out_if.source pix_out_o
);

  typedef struct packed {
    logic [WinSize-1:0][PixW-1:0] vals;
    logic [WinSize-1:0]           alive;
    logic [RankW-1:0]             rank;
    pix_t                         res;
    pix_t                         center;
    logic                         border;
    logic                         fend;
  } rx_t;

  function automatic logic [RankW:0] count_ones(input logic [WinSize-1:0] v);
    logic [RankW:0] n;
    n = '0;
    for (int i = 0; i < WinSize; i++) n = n + (RankW + 1)'(v[i]);
    return n;
  endfunction

  // Read stage: line store data arrives here
  logic   s1_v_q;
  issue_t s1_q;

  // Window stage
  logic            w_v_q;
  pix_t            win_q [StoreRows][StoreRows];
  logic            w_border_q;
  logic            w_fend_q;
  pix_t            w_center_q;
  logic [RadW-1:0] w_rad_q;
  logic            rdy_w;
  pix_t            col_v [StoreRows];

  // Median stages
  logic [PixW-1:0] rv_q;
  logic [PixW-1:0] rdy;
  rx_t             rx_q   [PixW];
  rx_t             st_in  [PixW];
  rx_t             st_out [PixW];

  assign rdy_w      = !w_v_q || rdy[0];
  assign in_ready_o = !s1_v_q || rdy_w;

  // Pick the column of window rows around the fetch row
  always_comb begin
    for (int k = 0; k < StoreRows; k++) begin
      col_v[k] = rd_a_i[row_wrap(5'(s1_q.row_a) + 5'(StoreRows) - 5'(s1_q.rad) + 5'(k))];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      w_v_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_v_q <= iss_i.due;
      end
      if (rdy_w) begin
        w_v_q <= s1_v_q;
      end
    end
  end

  // Capture side data on issue; shift the window by one column per item
  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      s1_q <= iss_i;
    end
    if (rdy_w && s1_v_q) begin
      for (int r = 0; r < StoreRows; r++) begin
        for (int c = 0; c < StoreRows - 1; c++) begin
          win_q[r][c] <= win_q[r][c+1];
        end
        win_q[r][StoreRows-1] <= col_v[r];
      end
      w_border_q <= s1_q.border;
      w_fend_q   <= s1_q.fend;
      w_center_q <= rd_b_i[s1_q.row_b];
      w_rad_q    <= s1_q.rad;
    end
  end

  // Seed the search: active window members and the middle rank
  always_comb begin
    st_in[0] = '0;
    for (int r = 0; r < StoreRows; r++) begin
      for (int c = 0; c < StoreRows; c++) begin
        st_in[0].vals[r*StoreRows+c]  = win_q[r][c];
        st_in[0].alive[r*StoreRows+c] = (r <= 2 * int'(w_rad_q)) &&
                                        (c >= int'(StoreRows) - 1 - 2 * int'(w_rad_q));
      end
    end
    st_in[0].rank   = RankW'(2 * int'(w_rad_q) * (int'(w_rad_q) + 1));
    st_in[0].center = w_center_q;
    st_in[0].border = w_border_q;
    st_in[0].fend   = w_fend_q;
  end

  for (genvar s = 0; s < PixW; s++) begin : g_stage
    logic [WinSize-1:0] bits;
    logic [WinSize-1:0] zeros;
    logic [RankW:0]     cnt;

    if (s > 0) begin : g_link
      assign st_in[s] = rx_q[s-1];
    end

    // Settle one result bit, most significant first
    always_comb begin
      for (int i = 0; i < WinSize; i++) bits[i] = st_in[s].vals[i][PixW-1-s];
      zeros     = st_in[s].alive & ~bits;
      cnt       = count_ones(zeros);
      st_out[s] = st_in[s];
      if ((RankW + 1)'(st_in[s].rank) < cnt) begin
        st_out[s].alive          = zeros;
        st_out[s].res[PixW-1-s]  = 1'b0;
      end else begin
        st_out[s].alive          = st_in[s].alive & bits;
        st_out[s].rank           = st_in[s].rank - cnt[RankW-1:0];
        st_out[s].res[PixW-1-s]  = 1'b1;
      end
      if ((s == PixW - 1) && st_in[s].border) begin
        st_out[s].res = st_in[s].center;
      end
    end

    if (s == PixW - 1) begin : g_last
      assign rdy[s] = !rv_q[s] || pix_out_o.ready;
    end else begin : g_mid
      assign rdy[s] = !rv_q[s] || rdy[s+1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        rv_q[s] <= (s == 0) ? w_v_q : rv_q[(s == 0) ? 0 : s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s]) begin
        rx_q[s] <= st_out[s];
      end
    end
  end

  assign pix_out_o.valid     = rv_q[PixW-1];
  assign pix_out_o.pixel_out = rx_q[PixW-1].res;
  assign pix_out_o.frame_end = rx_q[PixW-1].fend;

endmodule

FILE: design/median_filter_window.sv
// Top level of the square-window median filter on a raster pixel stream.
// Depends on mfw_pkg, mfw_if, mfw_line_ram, mfw_ctrl and mfw_median.
//
//   channel    dir   payload                         handshake
//   cfg_i      in    index[1:0], data[15:0]          valid/ready, ready always high
//   pix_in_i   in    mode, pixel_in[7:0]             valid/ready
//   pix_out_o  out   pixel_out[7:0], frame_end       valid/ready
//
// One item per clock sustained while the output does not stall.
// The rate is set by the line store rows: one write and two reads per cycle.
// Reset restores the default config and clears all counters and valids;
// the line store needs no clearing pass.
// A stall at the output fills the bubbles in the median pipeline first, then
// holds the input.
module median_filter_window
  import mfw_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  mfw_cfg_if.sink       cfg_i,
  mfw_pix_in_if.sink    pix_in_i,
  mfw_pix_out_if.source pix_out_o
);

  issue_t iss;
  wr_t    wr;
  logic   in_ready;
  pix_t   rd_a [StoreRows];
  pix_t   rd_b [StoreRows];

  mfw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .pix_in_i   (pix_in_i),
    .in_ready_i (in_ready),
    .iss_o      (iss),
    .wr_o       (wr)
  );

  // Line store, one memory per stored row
  for (genvar i = 0; i < StoreRows; i++) begin : g_row
    mfw_line_ram u_ram (
      .clk_i     (clk_i),
      .we_i      (wr.en && (wr.row == RowPtrW'(i))),
      .waddr_i   (wr.col),
      .wdata_i   (wr.data),
      .re_i      (in_ready),
      .raddr_a_i (iss.col_a),
      .raddr_b_i (iss.col_b),
      .rdata_a_o (rd_a[i]),
      .rdata_b_o (rd_b[i])
    );
  end

  mfw_median u_median (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .iss_i      (iss),
    .rd_a_i     (rd_a),
    .rd_b_i     (rd_b),
    .in_ready_o (in_ready),
    .pix_out_o  (pix_out_o)
  );

endmodule

FILE: dv/mfw_checker.sv
`timescale 1ns / 1ps
// Checker of the median filter window: watches the config, pixel in and pixel out
// channels, predicts every output item and compares it. Depends on mfw_pkg, mfw_if.
module mfw_checker
  import mfw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mfw_cfg_if          cfg,
  mfw_pix_in_if       pix_in,
  mfw_pix_out_if      pix_out,
  output int unsigned fail_count_o,
  output int unsigned owed_count_o,
  output int unsigned result_count_o
);

  typedef struct {
    pix_t pixel;
    logic fend;
  } filtered_t;

  filtered_t owed_q[$];

  logic [RadW-1:0]    radius_q;
  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  pix_t               rows_q [StoreRows*MaxWidth];
  int unsigned        col_q, row_q, sent_q;

  assign owed_count_o = owed_q.size();

  function automatic pix_t stored(int unsigned y, int unsigned x);
    return rows_q[(y % StoreRows) * MaxWidth + (x % MaxWidth)];
  endfunction

  // Median of the window centred on (y, x), or the pixel itself at the border
  function automatic pix_t filter_at(int unsigned y, int unsigned x, int unsigned r,
                                     int unsigned w, int unsigned h);
    pix_t        win[WinSize];
    pix_t        v;
    int unsigned n;
    int          j;
    n = 0;
    if (y < r || x < r || y + r >= h || x + r >= w) return stored(y, x);
    for (int unsigned i = y - r; i <= y + r; i++)
      for (int unsigned k = x - r; k <= x + r; k++) begin
        win[n] = stored(i, k);
        n++;
      end
    // insertion sort, ascending
    for (int unsigned i = 1; i < n; i++) begin
      v = win[i];
      j = i;
      while (j > 0 && win[j-1] > v) begin
        win[j] = win[j-1];
        j--;
      end
      win[j] = v;
    end
    return win[(n - 1) / 2];
  endfunction

  // Advance the prediction by one accepted input item
  function automatic void take_item(logic flush, pix_t px);
    int unsigned r, w, h, total, lag, avail;
    filtered_t   res;
    r = (radius_q > MaxRadius) ? MaxRadius : radius_q;
    w = (width_q == 0) ? 1 : ((width_q > MaxWidth) ? MaxWidth : width_q);
    h = (height_q == 0) ? 1 : height_q;
    total = w * h;
    lag = r * w + r;
    avail = row_q * w + col_q;
    if (!flush && avail < total) begin
      rows_q[(row_q % StoreRows) * MaxWidth + (col_q % MaxWidth)] = px;
      col_q++;
      if (col_q >= w) begin
        col_q = 0;
        row_q++;
      end
      avail++;
    end
    if (sent_q >= total) begin
      col_q = 0; row_q = 0; sent_q = 0;
      return;
    end
    if (!((sent_q + lag < avail) || (avail >= total))) return;
    res.pixel = filter_at(sent_q / w, sent_q % w, r, w, h);
    sent_q++;
    res.fend = (sent_q >= total);
    if (res.fend) begin
      col_q = 0; row_q = 0; sent_q = 0;
    end
    owed_q.push_back(res);
  endfunction

  // Track config, predict on input, compare on output
  always @(posedge clk_i or negedge rst_ni) begin
    filtered_t exp_item;
    if (!rst_ni) begin
      radius_q = 2'd1;
      width_q = 11'd640;
      height_q = 16'd480;
      col_q = 0; row_q = 0; sent_q = 0;
      foreach (rows_q[i]) rows_q[i] = '0;
      owed_q.delete();
      fail_count_o <= 0;
      result_count_o <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_idx_e'(cfg.index))
          CFG_RADIUS: radius_q = cfg.data[RadW-1:0];
          CFG_WIDTH:  width_q = cfg.data[WidthW-1:0];
          CFG_HEIGHT: height_q = cfg.data[HeightW-1:0];
          default: ;
        endcase
      end
      if (pix_in.valid && pix_in.ready) take_item(pix_in.mode, pix_in.pixel_in);
      if (pix_out.valid && pix_out.ready) begin
        result_count_o <= result_count_o + 1;
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected item pixel_out=%0d frame_end=%0b", $time,
                   pix_out.pixel_out, pix_out.frame_end);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_item = owed_q.pop_front();
          if (pix_out.pixel_out !== exp_item.pixel || pix_out.frame_end !== exp_item.fend)
          begin
            $display("%0t: mismatch expected pixel_out=%0d frame_end=%0b, got %0d %0b",
                     $time, exp_item.pixel, exp_item.fend, pix_out.pixel_out,
                     pix_out.frame_end);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Top of the median filter window testbench: clock, reset, stimulus and verdict.
// Depends on mfw_pkg, mfw_if, the block and mfw_checker.
module testbench;
  import mfw_pkg::*;

  localparam int unsigned CycleLimit = 300000;

  logic        clk, rst_n;
  logic        calm;
  int unsigned fails, owed, results, cycles, pixels_sent, frames;

  mfw_cfg_if     cfg ();
  mfw_pix_in_if  pix_in ();
  mfw_pix_out_if pix_out ();

  median_filter_window dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .cfg_i    (cfg),
    .pix_in_i (pix_in),
    .pix_out_o(pix_out)
  );

  mfw_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg           (cfg),
    .pix_in        (pix_in),
    .pix_out       (pix_out),
    .fail_count_o  (fails),
    .owed_count_o  (owed),
    .result_count_o(results)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Stall the output at random
  always @(posedge clk) begin
    pix_out.ready <= calm || ($urandom_range(99) >= 37);
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Send one item, idling at random first; valid stays high into the next item
  task automatic send_item(logic flush, pix_t px);
    while (!calm && $urandom_range(99) < 37) begin
      pix_in.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.mode <= flush;
    pix_in.pixel_in <= flush ? pix_t'($urandom) : px;
    do @(posedge clk); while (!pix_in.ready);
    if (!flush) pixels_sent++;
  endtask

  // Hold until every owed item has come out and the pipeline has settled
  task automatic drain_wait();
    pix_in.valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic set_config(int unsigned r, int unsigned w, int unsigned h);
    cfg_write(CFG_RADIUS, CfgDataW'(r));
    cfg_write(CFG_WIDTH, CfgDataW'(w));
    cfg_write(CFG_HEIGHT, CfgDataW'(h));
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic pix_t pick_pixel();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return pix_t'($urandom);
    endcase
  endfunction

  // One whole frame: pixels with stray flushes, then enough flushes to empty it
  task automatic run_frame(int unsigned r, int unsigned w, int unsigned h);
    int unsigned ew, eh;
    ew = (w == 0) ? 1 : ((w > MaxWidth) ? MaxWidth : w);
    eh = (h == 0) ? 1 : h;
    set_config(r, w, h);
    for (int unsigned i = 0; i < ew * eh; i++) begin
      if ($urandom_range(99) < 8) send_item(1'b1, '0);
      send_item(1'b0, pick_pixel());
    end
    for (int unsigned i = 0; i < r * ew + r + 2; i++) send_item(1'b1, '0);
    frames++;
    drain_wait();
  endtask

  initial begin
    int unsigned r, w, h;
    calm = 1'b0;
    cycles = 0;
    pixels_sent = 0;
    frames = 0;
    rst_n = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = CFG_RADIUS;
    cfg.data = '0;
    pix_in.valid = 1'b0;
    pix_in.mode = 1'b0;
    pix_in.pixel_in = '0;
    pix_out.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 3x3 frame: flush with nothing owed, early flush, extremes, dropped pixels
    set_config(1, 3, 3);
    send_item(1'b1, '0);
    send_item(1'b0, 8'd255);
    send_item(1'b0, 8'd0);
    send_item(1'b1, '0);
    send_item(1'b0, 8'd255);
    send_item(1'b0, 8'd0);
    send_item(1'b0, 8'd128);
    send_item(1'b0, 8'd1);
    send_item(1'b0, 8'd254);
    send_item(1'b0, 8'd127);
    send_item(1'b0, 8'd255);
    send_item(1'b0, 8'd170);
    send_item(1'b0, 8'd85);
    send_item(1'b1, '0);
    send_item(1'b1, '0);
    send_item(1'b1, '0);
    pixels_sent -= 2;
    frames++;
    drain_wait();
    // zero width and height act as a one-pixel frame
    run_frame(0, 0, 0);
    run_frame(2, 4, 2);

    // Random frames, a calm stretch in the middle
    while (pixels_sent < 520) begin
      calm = (pixels_sent > 200 && pixels_sent < 300);
      r = $urandom_range(3);
      w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      h = $urandom_range(1, 10);
      run_frame(r, w, h);
    end
    calm = 1'b0;
    // Saturated width and the tallest frame, left unfinished
    set_config(3, 2047, 65535);
    for (int i = 0; i < 30; i++) send_item(1'b0, pick_pixel());
    drain_wait();

    $display("Sent %0d pixels over %0d frames, radius 0 to 3, widths 1 to 40;",
             pixels_sent, frames);
    $display("%0d filtered items came out and were checked.", results);
    if (fails == 0 && owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/mfw_pkg.sv
design/mfw_if.sv
design/mfw_line_ram.sv
design/mfw_ctrl.sv
design/mfw_median.sv
design/median_filter_window.sv
dv/mfw_checker.sv
dv/testbench.sv
